FILE: hdl/pcn_pkg.sv
// Shared types, constants and controller/datapath interface for per_class_nms.
// Used by every module in hdl/ except pcn_ram; depends on nothing.
package pcn_pkg;

    localparam int MAX_DETS_DEF   = 64;
    localparam int CLASS_BITS_DEF = 8;
    localparam int BOX_BITS       = 62;
    localparam int SCORE_BITS     = 16;
    localparam int ADDR_BITS      = 3;

    localparam logic [15:0] IOU_THR_RESET = 16'd29491;

    // Register index, taken from paddr[2]
    localparam logic REG_IOU_THR = 1'b0;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
        logic [15:0]        score;
        logic [7:0]         class_id;
        logic               last;
    } item_t;

    typedef struct packed {
        logic signed [15:0] kept_x;
        logic signed [15:0] kept_y;
        logic [14:0]        kept_w;
        logic [14:0]        kept_h;
        logic [15:0]        kept_score;
        logic [7:0]         kept_class;
        logic               final_res;
        logic               overflow;
    } res_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_RK_RDI,
        ST_RK_LATI,
        ST_RK_CMP,
        ST_RK_WR,
        ST_WK_NEXT,
        ST_WK_RDA,
        ST_WK_LATA,
        ST_WK_AREA,
        ST_WK_J,
        ST_WK_RDB,
        ST_WK_LATB,
        ST_WK_C1,
        ST_WK_C2,
        ST_WK_C3,
        ST_WK_C4,
        ST_WK_C5,
        ST_WK_CMP,
        ST_WK_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic rk_rd_i;
        logic rk_lat_i;
        logic rk_step;
        logic rk_wr;
        logic skip_i;
        logic rd_oi;
        logic rd_da;
        logic lat_a;
        logic area;
        logic skip_j;
        logic rd_oj;
        logic rd_db;
        logic lat_b;
        logic c1;
        logic c2;
        logic c3;
        logic c4;
        logic c5;
        logic cmp;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic rk_j_last;
        logic rk_i_last;
        logic i_end;
        logic supp_i;
        logic j_end;
        logic supp_j;
        logic class_match;
    } sts_t;

endpackage

FILE: hdl/pcn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/pcn_ctrl.sv
// Sequencer for per_class_nms: load, rank and greedy suppression walk.
// Depends on pcn_pkg.
module pcn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last,
    input  pcn_pkg::sts_t sts,
    output pcn_pkg::cmd_t cmd,
    output logic          busy
);

    pcn_pkg::state_t state_reg;
    pcn_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcn_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            pcn_pkg::ST_LOAD:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last)
                    begin
                        state_next = pcn_pkg::ST_RK_RDI;
                    end
                end
            end
            pcn_pkg::ST_RK_RDI:
            begin
                cmd.rk_rd_i = 1'b1;
                state_next  = pcn_pkg::ST_RK_LATI;
            end
            pcn_pkg::ST_RK_LATI:
            begin
                cmd.rk_lat_i = 1'b1;
                state_next   = pcn_pkg::ST_RK_CMP;
            end
            pcn_pkg::ST_RK_CMP:
            begin
                cmd.rk_step = 1'b1;
                if (sts.rk_j_last)
                begin
                    state_next = pcn_pkg::ST_RK_WR;
                end
            end
            pcn_pkg::ST_RK_WR:
            begin
                cmd.rk_wr  = 1'b1;
                state_next = sts.rk_i_last ? pcn_pkg::ST_WK_NEXT : pcn_pkg::ST_RK_RDI;
            end
            pcn_pkg::ST_WK_NEXT:
            begin
                if (sts.i_end)
                begin
                    state_next = pcn_pkg::ST_WK_FIN;
                end
                else if (sts.supp_i)
                begin
                    cmd.skip_i = 1'b1;
                end
                else
                begin
                    cmd.rd_oi  = 1'b1;
                    state_next = pcn_pkg::ST_WK_RDA;
                end
            end
            pcn_pkg::ST_WK_RDA:
            begin
                cmd.rd_da  = 1'b1;
                state_next = pcn_pkg::ST_WK_LATA;
            end
            pcn_pkg::ST_WK_LATA:
            begin
                cmd.lat_a  = 1'b1;
                state_next = pcn_pkg::ST_WK_AREA;
            end
            pcn_pkg::ST_WK_AREA:
            begin
                cmd.area   = 1'b1;
                state_next = pcn_pkg::ST_WK_J;
            end
            pcn_pkg::ST_WK_J:
            begin
                if (sts.j_end)
                begin
                    cmd.skip_i = 1'b1;
                    state_next = pcn_pkg::ST_WK_NEXT;
                end
                else if (sts.supp_j)
                begin
                    cmd.skip_j = 1'b1;
                end
                else
                begin
                    cmd.rd_oj  = 1'b1;
                    state_next = pcn_pkg::ST_WK_RDB;
                end
            end
            pcn_pkg::ST_WK_RDB:
            begin
                cmd.rd_db  = 1'b1;
                state_next = pcn_pkg::ST_WK_LATB;
            end
            pcn_pkg::ST_WK_LATB:
            begin
                if (sts.class_match)
                begin
                    cmd.lat_b  = 1'b1;
                    state_next = pcn_pkg::ST_WK_C1;
                end
                else
                begin
                    cmd.skip_j = 1'b1;
                    state_next = pcn_pkg::ST_WK_J;
                end
            end
            pcn_pkg::ST_WK_C1:
            begin
                cmd.c1     = 1'b1;
                state_next = pcn_pkg::ST_WK_C2;
            end
            pcn_pkg::ST_WK_C2:
            begin
                cmd.c2     = 1'b1;
                state_next = pcn_pkg::ST_WK_C3;
            end
            pcn_pkg::ST_WK_C3:
            begin
                cmd.c3     = 1'b1;
                state_next = pcn_pkg::ST_WK_C4;
            end
            pcn_pkg::ST_WK_C4:
            begin
                cmd.c4     = 1'b1;
                state_next = pcn_pkg::ST_WK_C5;
            end
            pcn_pkg::ST_WK_C5:
            begin
                cmd.c5     = 1'b1;
                state_next = pcn_pkg::ST_WK_CMP;
            end
            pcn_pkg::ST_WK_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = pcn_pkg::ST_WK_J;
            end
            pcn_pkg::ST_WK_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = pcn_pkg::ST_LOAD;
            end
            default:
            begin
                state_next = pcn_pkg::ST_LOAD;
            end
        endcase
    end

    assign busy = (state_reg != pcn_pkg::ST_LOAD);

endmodule

FILE: hdl/pcn_dp.sv
// Datapath for per_class_nms: detection and order memories, counters,
// rank compare, IoU arithmetic and result registers. Depends on pcn_pkg, pcn_ram.
module pcn_dp #(
    parameter int MAX_DETS   = pcn_pkg::MAX_DETS_DEF,
    parameter int CLASS_BITS = pcn_pkg::CLASS_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  pcn_pkg::cmd_t  cmd,
    input  pcn_pkg::item_t item,
    input  logic [15:0]    thr,
    output pcn_pkg::sts_t  sts,
    output logic           res_valid,
    output pcn_pkg::res_t  res
);

    localparam int AW = $clog2(MAX_DETS);
    localparam int CW = $clog2(MAX_DETS + 1);
    localparam int SB = pcn_pkg::BOX_BITS;
    localparam int DW = SB + pcn_pkg::SCORE_BITS + CLASS_BITS;

    logic [CW-1:0]         cnt_reg;
    logic                  dropped_reg;
    logic [CW-1:0]         i_reg;
    logic [CW-1:0]         j_reg;
    logic [AW-1:0]         rank_reg;
    logic [MAX_DETS-1:0]   supp_reg;
    logic                  pend_valid_reg;
    logic                  out_valid_reg;

    logic [15:0]           score_i_reg;
    logic [DW-1:0]         pend_reg;
    pcn_pkg::res_t         res_reg;

    logic signed [15:0]    a_x_reg, a_y_reg, b_x_reg, b_y_reg;
    logic [14:0]           a_w_reg, a_h_reg, b_w_reg, b_h_reg;
    logic [CLASS_BITS-1:0] a_cls_reg;
    logic [29:0]           area_a_reg, area_b_reg;
    logic signed [15:0]    x1_reg, y1_reg;
    logic signed [16:0]    x2_reg, y2_reg;
    logic [16:0]           dx_reg, dy_reg;
    logic [33:0]           inter_reg;
    logic [31:0]           uni_p1_reg;
    logic [47:0]           rhs_reg;

    // Memory ports
    logic                  d_we;
    logic [AW-1:0]         d_raddr;
    logic [DW-1:0]         d_wdata;
    logic [DW-1:0]         d_rdata;
    logic [AW-1:0]         o_raddr;
    logic [AW-1:0]         o_rdata;

    logic [15:0]           cls_ext;
    logic                  full;
    logic [CW-1:0]         j_plus;
    logic [CW-1:0]         n_minus;
    logic signed [15:0]    d_x, d_y;
    logic [14:0]           d_w, d_h;
    logic [15:0]           d_score;
    logic [CLASS_BITS-1:0] d_cls;
    logic                  beats;
    logic                  over;
    logic signed [16:0]    a_xe, a_ye, b_xe, b_ye;
    logic signed [17:0]    dx_s, dy_s;
    logic [15:0]           pend_cls_ext;

    assign cls_ext = {8'd0, item.class_id};
    assign full    = (cnt_reg == CW'(MAX_DETS));
    assign j_plus  = j_reg + 1'b1;
    assign n_minus = cnt_reg - 1'b1;

    assign d_we    = cmd.load && !full;
    assign d_wdata = {cls_ext[CLASS_BITS-1:0], item.score, item.box_h, item.box_w,
                      item.box_y, item.box_x};

    always_comb
    begin
        if (cmd.rk_rd_i)
        begin
            d_raddr = i_reg[AW-1:0];
        end
        else if (cmd.rk_lat_i)
        begin
            d_raddr = '0;
        end
        else if (cmd.rk_step)
        begin
            d_raddr = j_plus[AW-1:0];
        end
        else
        begin
            d_raddr = o_rdata;
        end
    end

    assign o_raddr = cmd.rd_oj ? j_reg[AW-1:0] : i_reg[AW-1:0];

    pcn_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_DETS)
    ) u_det_ram (
        .clk   (clk),
        .we    (d_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    pcn_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_DETS)
    ) u_ord_ram (
        .clk   (clk),
        .we    (cmd.rk_wr),
        .waddr (rank_reg),
        .wdata (i_reg[AW-1:0]),
        .raddr (o_raddr),
        .rdata (o_rdata)
    );

    assign d_x     = d_rdata[15:0];
    assign d_y     = d_rdata[31:16];
    assign d_w     = d_rdata[46:32];
    assign d_h     = d_rdata[61:47];
    assign d_score = d_rdata[SB +: 16];
    assign d_cls   = d_rdata[DW-1 -: CLASS_BITS];

    // Earlier entries win ties, so the order stays stable
    always_comb
    begin
        if (j_reg < i_reg)
        begin
            beats = (d_score >= score_i_reg);
        end
        else if (j_reg > i_reg)
        begin
            beats = (d_score > score_i_reg);
        end
        else
        begin
            beats = 1'b0;
        end
    end

    assign a_xe = 17'(a_x_reg) + $signed({2'b00, a_w_reg});
    assign a_ye = 17'(a_y_reg) + $signed({2'b00, a_h_reg});
    assign b_xe = 17'(b_x_reg) + $signed({2'b00, b_w_reg});
    assign b_ye = 17'(b_y_reg) + $signed({2'b00, b_h_reg});
    assign dx_s = 18'(x2_reg) - 18'(x1_reg);
    assign dy_s = 18'(y2_reg) - 18'(y1_reg);

    assign over = ({inter_reg, 16'd0} > {2'b00, rhs_reg});

    assign sts.rk_j_last   = (j_reg == n_minus);
    assign sts.rk_i_last   = (i_reg == n_minus);
    assign sts.i_end       = (i_reg == cnt_reg);
    assign sts.j_end       = (j_reg == cnt_reg);
    assign sts.supp_i      = supp_reg[i_reg[AW-1:0]];
    assign sts.supp_j      = supp_reg[j_reg[AW-1:0]];
    assign sts.class_match = (d_cls == a_cls_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            dropped_reg    <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            rank_reg       <= '0;
            supp_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Release the pending kept box when the next one is latched or at the end
            out_valid_reg <= (cmd.lat_a || cmd.fin) && pend_valid_reg;
            if (cmd.load)
            begin
                i_reg <= '0;
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.rk_lat_i)
            begin
                j_reg    <= '0;
                rank_reg <= '0;
            end
            if (cmd.rk_step)
            begin
                j_reg    <= j_plus;
                rank_reg <= rank_reg + AW'(beats);
            end
            if (cmd.rk_wr)
            begin
                i_reg <= sts.rk_i_last ? '0 : i_reg + 1'b1;
            end
            if (cmd.skip_i)
            begin
                i_reg <= i_reg + 1'b1;
            end
            if (cmd.lat_a)
            begin
                j_reg          <= i_reg + 1'b1;
                pend_valid_reg <= 1'b1;
            end
            if (cmd.skip_j)
            begin
                j_reg <= j_plus;
            end
            if (cmd.cmp)
            begin
                j_reg <= j_plus;
                if (over)
                begin
                    supp_reg[j_reg[AW-1:0]] <= 1'b1;
                end
            end
            if (cmd.fin)
            begin
                pend_valid_reg <= 1'b0;
                cnt_reg        <= '0;
                dropped_reg    <= 1'b0;
                supp_reg       <= '0;
            end
        end
    end

    assign pend_cls_ext = 16'(pend_reg[DW-1 -: CLASS_BITS]);

    always_ff @(posedge clk)
    begin
        if (cmd.rk_lat_i)
        begin
            score_i_reg <= d_score;
        end
        if (cmd.lat_a || cmd.fin)
        begin
            res_reg.kept_x     <= pend_reg[15:0];
            res_reg.kept_y     <= pend_reg[31:16];
            res_reg.kept_w     <= pend_reg[46:32];
            res_reg.kept_h     <= pend_reg[61:47];
            res_reg.kept_score <= pend_reg[SB +: 16];
            res_reg.kept_class <= pend_cls_ext[7:0];
            res_reg.final_res  <= cmd.fin;
            res_reg.overflow   <= dropped_reg;
        end
        if (cmd.lat_a)
        begin
            pend_reg  <= d_rdata;
            a_x_reg   <= d_x;
            a_y_reg   <= d_y;
            a_w_reg   <= d_w;
            a_h_reg   <= d_h;
            a_cls_reg <= d_cls;
        end
        if (cmd.area)
        begin
            area_a_reg <= a_w_reg * a_h_reg;
        end
        if (cmd.lat_b)
        begin
            b_x_reg <= d_x;
            b_y_reg <= d_y;
            b_w_reg <= d_w;
            b_h_reg <= d_h;
        end
        if (cmd.c1)
        begin
            x1_reg <= (a_x_reg > b_x_reg) ? a_x_reg : b_x_reg;
            y1_reg <= (a_y_reg > b_y_reg) ? a_y_reg : b_y_reg;
            x2_reg <= (a_xe < b_xe) ? a_xe : b_xe;
            y2_reg <= (a_ye < b_ye) ? a_ye : b_ye;
        end
        if (cmd.c2)
        begin
            dx_reg <= (dx_s > 18'sd0) ? dx_s[16:0] : '0;
            dy_reg <= (dy_s > 18'sd0) ? dy_s[16:0] : '0;
        end
        if (cmd.c3)
        begin
            inter_reg  <= dx_reg * dy_reg;
            area_b_reg <= b_w_reg * b_h_reg;
        end
        if (cmd.c4)
        begin
            // Intersection never exceeds the smaller area, so the union fits
            uni_p1_reg <= 32'(area_a_reg) + 32'(area_b_reg) - inter_reg[31:0] + 32'd1;
        end
        if (cmd.c5)
        begin
            rhs_reg <= thr * uni_p1_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

FILE: hdl/per_class_nms.sv
// Top level of per_class_nms: APB threshold register, sequencer and datapath.
// Depends on pcn_pkg, pcn_ctrl, pcn_dp (and through it pcn_ram).
//
// Greedy per-class non-maximum suppression. Detections are loaded one per
// cycle with start while busy is low; the item marked last closes the set and
// raises busy. The set of n stored entries (at most MAX_DETS, further items
// are dropped and flagged on overflow) is then ranked by descending score,
// ties in load order, by comparing every entry with every other one through
// the single read port of the detection memory. The walk then visits the
// ranked list; for each kept box every later, unsuppressed box is read and,
// if of the same class, put through the IoU test (a chain of registered
// steps with a final compare). Kept boxes leave in score order on res
// with a single-cycle res_valid strobe; the receiver cannot stall and must
// take each item in the cycle it appears. The last kept box carries
// final_res and busy falls in the same cycle.
// The threshold (Q0.16 at byte address 0) may be written only while idle.
module per_class_nms #(
    parameter int MAX_DETS   = pcn_pkg::MAX_DETS_DEF,
    parameter int CLASS_BITS = pcn_pkg::CLASS_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel
    input  logic                            start,
    output logic                            busy,
    input  pcn_pkg::item_t                  item,
    // Result channel
    output logic                            res_valid,
    output pcn_pkg::res_t                   res,
    // Configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pcn_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    pcn_pkg::cmd_t cmd;
    pcn_pkg::sts_t sts;
    logic [15:0]   thr_reg;
    logic          cfg_wr;

    // Register is decoded from the word address bit only
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pcn_pkg::REG_IOU_THR);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pcn_pkg::REG_IOU_THR) ? {16'd0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= pcn_pkg::IOU_THR_RESET;
        end
        else if (cfg_wr)
        begin
            thr_reg <= pwdata[15:0];
        end
    end

    // Sequencer: load, rank, walk, flush
    pcn_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (item.last),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Stores, arithmetic and result registers
    pcn_dp #(
        .MAX_DETS   (MAX_DETS),
        .CLASS_BITS (CLASS_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .thr       (thr_reg),
        .sts       (sts),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

FILE: hdl/pcn_chk.sv
// Port-level checker for per_class_nms, bound to the top level.
// Depends on pcn_pkg.
module pcn_chk (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input pcn_pkg::item_t item,
    input logic           res_valid,
    input pcn_pkg::res_t  res
);

    // Results only come out of a processing pass
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // A closing item starts processing
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last) |=> busy)
        else $error("busy not raised after closing item");

    // The final item ends the pass
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.final_res) |-> !busy)
        else $error("final item while still busy");

    // Every pass ends with a final item
    a_fall_final: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (res_valid && res.final_res))
        else $error("pass ended without a final item");

endmodule

bind per_class_nms pcn_chk u_pcn_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
);
